// File: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the parameter set scanner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/hpss_pkg.sv
// Package: types and constants of the H.264 parameter set scanner
`timescale 1ns / 1ps
`default_nettype none

package hpss_pkg;

    localparam int unsigned MAX_UNIT_BYTES = 1048576;

    localparam int unsigned OFF_W = 20;
    localparam int unsigned LEN_W = 21;
    localparam int unsigned TYPE_W = 5;

    localparam logic [LEN_W-1:0] MAX_POS = LEN_W'(MAX_UNIT_BYTES);

    localparam logic [31:0] START_CODE = 32'h0000_0001;
    localparam logic [2:0] FILL_FULL = 3'd4;

    localparam logic [TYPE_W-1:0] NAL_SLICE = 5'h01;
    localparam logic [TYPE_W-1:0] NAL_IDR = 5'h05;
    localparam logic [TYPE_W-1:0] NAL_SPS = 5'h07;
    localparam logic [TYPE_W-1:0] NAL_PPS = 5'h08;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    // Event passed from the byte front end to the region tracker
    typedef struct packed {
        logic              sc;        // start code complete, type known
        logic [OFF_W-1:0]  sc_off;
        logic [TYPE_W-1:0] sc_type;
        logic              last;      // buffer ends with this byte
        logic [LEN_W-1:0]  length;    // buffer length (saturated)
        logic              too_long;
    } token_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic [OFF_W-1:0] sps_offset;
        logic [LEN_W-1:0] sps_length;
        logic [OFF_W-1:0] pps_offset;
        logic [LEN_W-1:0] pps_length;
        logic             key_frame_sync;
        logic             slice_before_key;
        logic [LEN_W-1:0] stop_offset;
        logic             too_long;
    } result_t;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_SECOND = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

endpackage

`default_nettype wire

// File: sv/hpss_ifs.sv
// Interfaces: byte input channel and result output channel
`timescale 1ns / 1ps
`default_nettype none

interface hpss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hpss_result_if import hpss_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] sps_offset;
    logic [LEN_W-1:0] sps_length;
    logic [OFF_W-1:0] pps_offset;
    logic [LEN_W-1:0] pps_length;
    logic             key_frame_sync;
    logic             slice_before_key;
    logic [LEN_W-1:0] stop_offset;
    logic             too_long;

    modport source (
        output valid, output sps_offset, output sps_length, output pps_offset,
        output pps_length, output key_frame_sync, output slice_before_key,
        output stop_offset, output too_long, input ready
    );
    modport sink (
        input valid, input sps_offset, input sps_length, input pps_offset,
        input pps_length, input key_frame_sync, input slice_before_key,
        input stop_offset, input too_long, output ready
    );
endinterface

`default_nettype wire

// File: sv/h264_parameter_set_scanner.sv
// H.264 Annex B parameter set scanner: usage
//   byte_chan takes one buffer byte per transaction; last_byte marks the
//   buffer's final byte. result_chan delivers one transaction per buffer
//   with the SPS and PPS regions (offset, length with start code), the
//   sync and slice-before-key flags, the stop offset and the overflow flag.
//   Throughput: one byte per cycle, sustained while the event queue is not full.
//   Result path: the last byte's event is written into the event queue, the
//   tracker pops it and loads the result register, which raises
//   result_chan.valid (front end -> 4-entry event queue -> region tracker -> result
//   register).
//   Only start codes and buffer ends enter the queue, so the tracker keeps up
//   with any byte stream; byte_chan.ready falls only when the queue is full.
//   Receiver stall: the result register holds the pending result; further
//   bytes keep flowing until the next buffer end reaches the tracker, then
//   the queue fills and byte_chan.ready drops.
//   Reset clears all buffer state and the sticky key-frame flag. Bytes past
//   MAX_UNIT_BYTES are not scanned and set too_long.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module h264_parameter_set_scanner import hpss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    hpss_byte_if.sink     byte_chan,
    hpss_result_if.source result_chan
);

    logic      q_push;
    token_t    q_token;
    logic      q_pop;
    logic      q_head_valid;
    token_t    q_head;
    q_status_t q_stat;
    logic      pop_last;

    hpss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .q_full    (q_stat.full),
        .q_push    (q_push),
        .q_token   (q_token)
    );

    hpss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_token   (q_token),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head),
        .stat       (q_stat)
    );

    hpss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head        (q_head),
        .pop         (q_pop),
        .result_chan (result_chan)
    );

    // buffer end taken by the tracker this cycle
    assign pop_last = q_stat.pop && q_head.last;

    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_stat.count <= Q_CNT_W'(Q_DEPTH), "queue overrun")
    `ASSERT_IMPLIES(a_no_drop, clk, rst_n, q_push, q_stat.push, "event lost at queue input")
    `ASSERT_IMPLIES(a_res_src, clk, rst_n, $rose(result_chan.valid), $past(pop_last), "stray result")

endmodule

`default_nettype wire

// File: sv/hpss_front.sv
// Front end: byte window, start code detection, position count
`timescale 1ns / 1ps
`default_nettype none

module hpss_front import hpss_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hpss_byte_if.sink   byte_chan,
    input  wire logic   q_full,
    output logic        q_push,
    output token_t      q_token
);

    logic [31:0]      recent_reg, recent_next;
    logic [2:0]       fill_reg, fill_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             too_long_reg, too_long_next;

    logic accept;
    logic scan;
    logic sc;

    assign byte_chan.ready = !q_full;
    assign accept = byte_chan.valid && !q_full;

    // bytes beyond the size limit only set the overflow flag
    assign scan = pos_reg < MAX_POS;
    assign sc = scan && (fill_reg == FILL_FULL) && (recent_reg == START_CODE);

    always_comb
    begin
        q_token.sc       = sc;
        q_token.sc_off   = OFF_W'(pos_reg - LEN_W'(4));
        q_token.sc_type  = byte_chan.data_byte[TYPE_W-1:0];
        q_token.last     = byte_chan.last_byte;
        q_token.length   = scan ? pos_reg + LEN_W'(1) : pos_reg;
        q_token.too_long = too_long_reg || !scan;
        q_push = accept && (sc || byte_chan.last_byte);
    end

    always_comb
    begin
        recent_next   = recent_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        too_long_next = too_long_reg;
        if (accept)
        begin
            if (byte_chan.last_byte)
            begin
                recent_next   = '0;
                fill_next     = '0;
                pos_next      = '0;
                too_long_next = 1'b0;
            end
            else if (scan)
            begin
                recent_next = {recent_reg[23:0], byte_chan.data_byte};
                if (fill_reg != FILL_FULL)
                begin
                    fill_next = fill_reg + 3'd1;
                end
                pos_next = pos_reg + LEN_W'(1);
            end
            else
            begin
                too_long_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg   <= '0;
            fill_reg     <= '0;
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
        end
        else
        begin
            recent_reg   <= recent_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            too_long_reg <= too_long_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hpss_queue.sv
// Short event queue between the front end and the region tracker
`timescale 1ns / 1ps
`default_nettype none

module hpss_queue import hpss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  token_t    wr_token,
    input  wire logic pop,
    output logic      head_valid,
    output token_t    head,
    output q_status_t stat
);

    token_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign head_valid = count_reg != '0;
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = push && (count_reg != Q_CNT_W'(Q_DEPTH));
    assign do_pop = pop && head_valid;

    always_comb
    begin
        stat.push  = do_push;
        stat.pop   = do_pop;
        stat.full  = count_reg == Q_CNT_W'(Q_DEPTH);
        stat.count = count_reg;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hpss_back.sv
// Region tracker: phase machine, SPS/PPS slots, result register
`timescale 1ns / 1ps
`default_nettype none

module hpss_back import hpss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     head_valid,
    input  token_t        head,
    output logic          pop,
    hpss_result_if.source result_chan
);

    phase_t            phase_reg, phase_next;
    logic [TYPE_W-1:0] first_type_reg, first_type_next;
    logic [TYPE_W-1:0] second_type_reg, second_type_next;
    logic [OFF_W-1:0]  start_reg, start_next;
    logic [OFF_W-1:0]  sps_off_reg, sps_off_next;
    logic [LEN_W-1:0]  sps_len_reg, sps_len_next;
    logic [OFF_W-1:0]  pps_off_reg, pps_off_next;
    logic [LEN_W-1:0]  pps_len_reg, pps_len_next;
    logic              sync_reg, sync_next;
    logic              sbk_reg, sbk_next;
    logic [LEN_W-1:0]  stop_reg, stop_next;
    logic              key_seen_reg, key_seen_next;

    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           res;

    logic [TYPE_W-1:0] t;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  open_len;

    assign t = head.sc_type;
    assign off = head.sc_off;
    assign open_len = {1'b0, off} - {1'b0, start_reg};

    // a buffer end waits only for the result register to free up
    assign pop = head_valid && (!head.last || !out_valid_reg || result_chan.ready);

    always_comb
    begin
        phase_next       = phase_reg;
        first_type_next  = first_type_reg;
        second_type_next = second_type_reg;
        start_next       = start_reg;
        sps_off_next     = sps_off_reg;
        sps_len_next     = sps_len_reg;
        pps_off_next     = pps_off_reg;
        pps_len_next     = pps_len_reg;
        sync_next        = sync_reg;
        sbk_next         = sbk_reg;
        stop_next        = stop_reg;
        key_seen_next    = key_seen_reg;

        if (head.sc)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (t inside {NAL_SPS, NAL_PPS})
                    begin
                        phase_next      = PH_FIRST;
                        first_type_next = t;
                        start_next      = off;
                    end
                    else if (t == NAL_SLICE)
                    begin
                        if (!key_seen_reg)
                        begin
                            sbk_next = 1'b1;
                        end
                        sync_next  = 1'b0;
                        stop_next  = {1'b0, off};
                        phase_next = PH_DONE;
                    end
                end
                PH_FIRST:
                begin
                    if (t != first_type_reg)
                    begin
                        if (first_type_reg == NAL_SPS)
                        begin
                            sps_off_next = start_reg;
                            sps_len_next = open_len;
                        end
                        else
                        begin
                            pps_off_next = start_reg;
                            pps_len_next = open_len;
                        end
                        second_type_next = t;
                        start_next       = off;
                        phase_next       = PH_SECOND;
                        // IDR right after the first region: empty region in the PPS slot
                        if (t == NAL_IDR)
                        begin
                            pps_off_next  = off;
                            pps_len_next  = '0;
                            sync_next     = 1'b1;
                            key_seen_next = 1'b1;
                            stop_next     = {1'b0, off};
                            phase_next    = PH_DONE;
                        end
                    end
                end
                PH_SECOND:
                begin
                    if (t == NAL_IDR)
                    begin
                        if (second_type_reg == NAL_SPS)
                        begin
                            sps_off_next = start_reg;
                            sps_len_next = open_len;
                        end
                        else
                        begin
                            pps_off_next = start_reg;
                            pps_len_next = open_len;
                        end
                        sync_next     = 1'b1;
                        key_seen_next = 1'b1;
                        stop_next     = {1'b0, off};
                        phase_next    = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.sps_offset       = sps_off_next;
        res.sps_length       = sps_len_next;
        res.pps_offset       = pps_off_next;
        res.pps_length       = pps_len_next;
        res.key_frame_sync   = sync_next;
        res.slice_before_key = sbk_next;
        res.stop_offset      = (phase_next == PH_DONE) ? stop_next : head.length;
        res.too_long         = head.too_long;

        if (head.last)
        begin
            phase_next       = PH_SEARCH;
            first_type_next  = '0;
            second_type_next = '0;
            start_next       = '0;
            sps_off_next     = '0;
            sps_len_next     = '0;
            pps_off_next     = '0;
            pps_len_next     = '0;
            sync_next        = 1'b0;
            sbk_next         = 1'b0;
            stop_next        = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && head.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEARCH;
            first_type_reg  <= '0;
            second_type_reg <= '0;
            start_reg       <= '0;
            sps_off_reg     <= '0;
            sps_len_reg     <= '0;
            pps_off_reg     <= '0;
            pps_len_reg     <= '0;
            sync_reg        <= 1'b0;
            sbk_reg         <= 1'b0;
            stop_reg        <= '0;
            key_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                first_type_reg  <= first_type_next;
                second_type_reg <= second_type_next;
                start_reg       <= start_next;
                sps_off_reg     <= sps_off_next;
                sps_len_reg     <= sps_len_next;
                pps_off_reg     <= pps_off_next;
                pps_len_reg     <= pps_len_next;
                sync_reg        <= sync_next;
                sbk_reg         <= sbk_next;
                stop_reg        <= stop_next;
                key_seen_reg    <= key_seen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_chan.valid            = out_valid_reg;
    assign result_chan.sps_offset       = out_reg.sps_offset;
    assign result_chan.sps_length       = out_reg.sps_length;
    assign result_chan.pps_offset       = out_reg.pps_offset;
    assign result_chan.pps_length       = out_reg.pps_length;
    assign result_chan.key_frame_sync   = out_reg.key_frame_sync;
    assign result_chan.slice_before_key = out_reg.slice_before_key;
    assign result_chan.stop_offset      = out_reg.stop_offset;
    assign result_chan.too_long         = out_reg.too_long;

endmodule

`default_nettype wire
